// File: rtl/core/crsh_pkg.sv
// Shared types, constants and tables for the closest ray-segment hit engine.
// No dependencies; the CORDIC, divider, top level and checker import it.
`timescale 1ns / 1ps

package crsh_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int ADDR_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_W = 64;

  localparam int CORDIC_STEPS = 14;
  localparam logic signed [16:0] CORDIC_X0 = 17'sd9949;

  // Divider sizes: a 61-bit magnitude numerator over a 35-bit magnitude divisor.
  localparam int NUM_W = 61;
  localparam int DEN_W = 35;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;

  localparam logic [1:0] CFG_PARALLEL_LIMIT = 2'd0;
  localparam logic [1:0] CFG_EDGE_MARGIN = 2'd1;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_CLEARED = 3'd2,
    ST_HIT     = 3'd3,
    ST_NOHIT   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_READ,
    S_PREP,
    S_MUL,
    S_CHECK,
    S_DIV2,
    S_DIV1,
    S_NEXT,
    S_HITX,
    S_HITY
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
    logic [DEN_W-1:0] denom;
  } div_req_t;

  function automatic logic signed [16:0] atan_units(input logic [3:0] i);
    logic signed [16:0] r;
    case (i)
      4'd0:    r = 17'sd8192;
      4'd1:    r = 17'sd4836;
      4'd2:    r = 17'sd2555;
      4'd3:    r = 17'sd1297;
      4'd4:    r = 17'sd651;
      4'd5:    r = 17'sd326;
      4'd6:    r = 17'sd163;
      4'd7:    r = 17'sd81;
      4'd8:    r = 17'sd41;
      4'd9:    r = 17'sd20;
      4'd10:   r = 17'sd10;
      4'd11:   r = 17'sd5;
      4'd12:   r = 17'sd3;
      4'd13:   r = 17'sd1;
      default: r = 17'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/crsh_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module crsh_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/crsh_cordic.sv
// Iterative CORDIC that turns a 16-bit angle into a Q2.14 unit direction.
// Depends on crsh_pkg for the arctangent table and the start value.
`timescale 1ns / 1ps

module crsh_cordic import crsh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [16:0] dx,
  output logic signed [16:0] dy
);

  logic               run_r, run_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [1:0]         quad_r, quad_nxt;
  logic signed [16:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [16:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic               done_r, done_nxt;
  logic signed [16:0] xs, ys, xn, yn;

  always_comb begin
    run_nxt  = run_r;
    step_nxt = step_r;
    quad_nxt = quad_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    done_nxt = 1'b0;
    xs = x_r >>> step_r;
    ys = y_r >>> step_r;
    if (!z_r[16]) begin
      xn = x_r - ys;
      yn = y_r + xs;
    end else begin
      xn = x_r + ys;
      yn = y_r - xs;
    end
    if (start) begin
      run_nxt  = 1'b1;
      step_nxt = 4'd0;
      quad_nxt = angle[15:14];
      x_nxt    = CORDIC_X0;
      y_nxt    = 17'sd0;
      z_nxt    = $signed({3'b000, angle[13:0]});
    end else if (run_r) begin
      x_nxt    = xn;
      y_nxt    = yn;
      z_nxt    = z_r[16] ? z_r + atan_units(step_r) : z_r - atan_units(step_r);
      step_nxt = step_r + 4'd1;
      if (step_r == 4'(CORDIC_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        case (quad_r)
          2'd0: begin
            dx_nxt = xn;
            dy_nxt = yn;
          end
          2'd1: begin
            dx_nxt = -yn;
            dy_nxt = xn;
          end
          2'd2: begin
            dx_nxt = -xn;
            dy_nxt = -yn;
          end
          default: begin
            dx_nxt = yn;
            dy_nxt = -xn;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quad_r <= quad_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
  end

  assign done = done_r;
  assign dx   = dx_r;
  assign dy   = dy_r;

endmodule

// File: rtl/core/crsh_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on crsh_pkg for widths and the request struct.
`timescale 1ns / 1ps

module crsh_div import crsh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     nq_r, nq_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W:0]       trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    nq_nxt   = nq_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, nq_r[NUM_W-1]};
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      nq_nxt  = req.numer;
      den_nxt = req.denom;
      rem_nxt = '0;
    end else if (run_r) begin
      // The numerator shifts out at the top while quotient bits shift in below.
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, den_r});
        nq_nxt  = {nq_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        nq_nxt  = {nq_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    nq_r  <= nq_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = nq_r;

endmodule

// File: rtl/core/closest_ray_segment_hit.sv
// Top level of the closest ray-segment hit engine: sequencer, segment store,
// CORDIC and divider. Depends on crsh_pkg, crsh_ram, crsh_cordic and crsh_div.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low, and exactly one
// result follows, shown for one cycle with out_valid; the receiver cannot
// stall it. Load and clear requests answer in the cycle after they are taken
// and leave busy low. A cast holds busy through the CORDIC and, for every
// stored segment, the store read, operand setup, six sequential multiplies
// through one shared multiplier and the parallel check, and then up to two
// passes of the bit-serial divider (the ray parameter along the segment
// first, along the ray only when the first passes), and then the steps that
// form the hit point; the result shows in the same cycle that busy falls.
// The segment store is a 256-entry memory with no reset; only entries below
// the segment count are ever read. Configuration writes are always accepted.

module closest_ray_segment_hit import crsh_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_x_a,
  input  logic signed [15:0] in_y_a,
  input  logic signed [15:0] in_x_b,
  input  logic signed [15:0] in_y_b,
  input  logic [15:0]        in_ray_angle,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [7:0]         out_seg_index,
  output logic signed [15:0] out_hit_x,
  output logic signed [15:0] out_hit_y,
  output logic [16:0]        out_hit_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [15:0]        limit_r, margin_r;
  logic signed [15:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [16:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [16:0] bx_r, bx_nxt, by_r, by_nxt, sx_r, sx_nxt, sy_r, sy_nxt;
  logic [2:0]         k_r, k_nxt;
  logic signed [34:0] acc_r, acc_nxt, d_r, d_nxt, n1_r, n1_nxt, n2_r, n2_nxt;
  logic               found_r, found_nxt;
  logic signed [61:0] best_r, best_nxt;
  logic [7:0]         best_idx_r, best_idx_nxt;
  logic signed [15:0] hx_r, hx_nxt;

  logic               ov_r, ov_nxt;
  logic [2:0]         ost_r, ost_nxt;
  logic [7:0]         oidx_r, oidx_nxt;
  logic signed [15:0] ohx_r, ohx_nxt, ohy_r, ohy_nxt;
  logic [16:0]        odist_r, odist_nxt;

  logic               accept;
  logic               ram_we, ram_re;
  logic [SEG_W-1:0]   ram_rdata;
  logic               cordic_start, cordic_done;
  logic signed [16:0] cordic_dx, cordic_dy;
  div_req_t           div_req;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;

  logic signed [16:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [50:0] mul_p;
  logic [34:0]        abs_d, abs_n1, abs_n2;
  logic signed [61:0] t_s, m_s, hi_s;
  logic               t_neg;
  logic [31:0]        tc;
  logic signed [50:0] rnd;
  logic signed [26:0] hsum;
  logic signed [15:0] hsat;
  logic [61:0]        dist_full;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= 16'd1;
      margin_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_PARALLEL_LIMIT) begin
        limit_r <= cfg_data;
      end else if (cfg_index == CFG_EDGE_MARGIN) begin
        margin_r <= cfg_data;
      end
    end
  end

  // The store is written only by load requests and read only during a cast,
  // so a write and a read of the same entry never overlap.
  assign ram_we = accept && (in_op == OP_LOAD) && (cnt_r < CNT_W'(MAX_SEGMENTS));
  assign ram_re = (state_r == S_READ);

  crsh_ram #(
    .WIDTH(SEG_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[ADDR_W-1:0]),
    .wr_data ({in_x_a, in_y_a, in_x_b, in_y_b}),
    .rd_en   (ram_re),
    .rd_addr (idx_r[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign cordic_start = accept && (in_op != OP_LOAD) && (in_op != OP_CLEAR);

  crsh_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (in_ray_angle),
    .done  (cordic_done),
    .dx    (cordic_dx),
    .dy    (cordic_dy)
  );

  crsh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // One shared multiplier: six products per segment, two for the hit point.
  assign tc = (best_r >= 62'sh8000_0000) ? 32'h8000_0000 : best_r[31:0];

  always_comb begin
    mul_a = dx_r;
    mul_b = 34'(by_r);
    if (state_r == S_HITX) begin
      mul_a = dx_r;
      mul_b = $signed({2'b00, tc});
    end else if (state_r == S_HITY) begin
      mul_a = dy_r;
      mul_b = $signed({2'b00, tc});
    end else begin
      case (k_r)
        3'd0: begin
          mul_a = dx_r;
          mul_b = 34'(by_r);
        end
        3'd1: begin
          mul_a = dy_r;
          mul_b = 34'(bx_r);
        end
        3'd2: begin
          mul_a = sx_r;
          mul_b = 34'(by_r);
        end
        3'd3: begin
          mul_a = sy_r;
          mul_b = 34'(bx_r);
        end
        3'd4: begin
          mul_a = sx_r;
          mul_b = 34'(dy_r);
        end
        default: begin
          mul_a = sy_r;
          mul_b = 34'(dx_r);
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  assign abs_d  = d_r[34]  ? 35'(-d_r)  : d_r;
  assign abs_n1 = n1_r[34] ? 35'(-n1_r) : n1_r;
  assign abs_n2 = n2_r[34] ? 35'(-n2_r) : n2_r;

  // The quotient is truncated toward zero: magnitude from the divider, sign
  // from the operands.
  assign t_neg = (state_r == S_DIV1) ? (n1_r[34] ^ d_r[34]) : (n2_r[34] ^ d_r[34]);
  assign t_s   = t_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  assign m_s   = $signed({46'd0, margin_r});
  assign hi_s  = 62'sd65536 - m_s;

  // Hit point rounding: add one half, floor by 2^26, add origin, saturate.
  assign rnd  = mul_p + 51'sd33554432;
  assign hsum = 27'((rnd >>> 26)) + 27'((state_r == S_HITX) ? ox_r : oy_r);
  assign hsat = (hsum > 27'sd32767) ? 16'sh7fff :
                (hsum < -27'sd32768) ? 16'sh8000 : hsum[15:0];

  assign dist_full = 62'(best_r + 62'sd2048) >> 12;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    bx_nxt       = bx_r;
    by_nxt       = by_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    k_nxt        = k_r;
    acc_nxt      = acc_r;
    d_nxt        = d_r;
    n1_nxt       = n1_r;
    n2_nxt       = n2_r;
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    hx_nxt       = hx_r;
    ov_nxt       = 1'b0;
    ost_nxt      = ost_r;
    oidx_nxt     = oidx_r;
    ohx_nxt      = ohx_r;
    ohy_nxt      = ohy_r;
    odist_nxt    = odist_r;
    div_req      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          oidx_nxt  = 8'd0;
          ohx_nxt   = 16'sd0;
          ohy_nxt   = 16'sd0;
          odist_nxt = 17'd0;
          if (in_op == OP_LOAD) begin
            ov_nxt = 1'b1;
            if (cnt_r < CNT_W'(MAX_SEGMENTS)) begin
              cnt_nxt = cnt_r + 1'b1;
              ost_nxt = ST_LOADED;
            end else begin
              ost_nxt = ST_FULL;
            end
          end else if (in_op == OP_CLEAR) begin
            ov_nxt  = 1'b1;
            cnt_nxt = '0;
            ost_nxt = ST_CLEARED;
          end else begin
            ox_nxt    = in_x_a;
            oy_nxt    = in_y_a;
            found_nxt = 1'b0;
            idx_nxt   = '0;
            state_nxt = S_CORDIC;
          end
        end
      end
      S_CORDIC: begin
        if (cordic_done) begin
          dx_nxt = cordic_dx;
          dy_nxt = cordic_dy;
          if (cnt_r == '0) begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_NOHIT;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_PREP;
      end
      S_PREP: begin
        bx_nxt    = 17'($signed(ram_rdata[31:16])) - 17'($signed(ram_rdata[63:48]));
        by_nxt    = 17'($signed(ram_rdata[15:0]))  - 17'($signed(ram_rdata[47:32]));
        sx_nxt    = 17'($signed(ram_rdata[63:48])) - 17'(ox_r);
        sy_nxt    = 17'($signed(ram_rdata[47:32])) - 17'(oy_r);
        k_nxt     = 3'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        k_nxt = k_r + 3'd1;
        case (k_r)
          3'd1: d_nxt  = acc_r - 35'(mul_p);
          3'd3: n1_nxt = acc_r - 35'(mul_p);
          3'd5: n2_nxt = acc_r - 35'(mul_p);
          default: acc_nxt = 35'(mul_p);
        endcase
        if (k_r == 3'd5) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((d_r == '0) || (abs_d < 35'(limit_r))) begin
          state_nxt = S_NEXT;
        end else begin
          div_req.start = 1'b1;
          div_req.numer = {10'd0, abs_n2, 16'd0};
          div_req.denom = abs_d;
          state_nxt     = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          if ((t_s > m_s) && (t_s < hi_s)) begin
            div_req.start = 1'b1;
            div_req.numer = {abs_n1, 26'd0};
            div_req.denom = abs_d;
            state_nxt     = S_DIV1;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          // Strictly smaller wins, so ties keep the lower index.
          if ((t_s > m_s) && (!found_r || (t_s < best_r))) begin
            found_nxt    = 1'b1;
            best_nxt     = t_s;
            best_idx_nxt = idx_r[7:0];
          end
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        idx_nxt = idx_r + 1'b1;
        if ((idx_r + 1'b1) == cnt_r) begin
          if (found_r) begin
            state_nxt = S_HITX;
          end else begin
            ov_nxt    = 1'b1;
            ost_nxt   = ST_NOHIT;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_READ;
        end
      end
      S_HITX: begin
        hx_nxt    = hsat;
        state_nxt = S_HITY;
      end
      S_HITY: begin
        ov_nxt    = 1'b1;
        ost_nxt   = ST_HIT;
        oidx_nxt  = best_idx_r;
        ohx_nxt   = hx_r;
        ohy_nxt   = hsat;
        odist_nxt = (dist_full > 62'd131071) ? 17'h1ffff : dist_full[16:0];
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r      <= idx_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    d_r        <= d_nxt;
    n1_r       <= n1_nxt;
    n2_r       <= n2_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    hx_r       <= hx_nxt;
    ost_r      <= ost_nxt;
    oidx_r     <= oidx_nxt;
    ohx_r      <= ohx_nxt;
    ohy_r      <= ohy_nxt;
    odist_r    <= odist_nxt;
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_seg_index    = oidx_r;
  assign out_hit_x        = ohx_r;
  assign out_hit_y        = ohy_r;
  assign out_hit_distance = odist_r;

endmodule

// File: rtl/core/crsh_checker.sv
// Port-level assertions for the closest ray-segment hit engine, bound to the top.
// Depends on crsh_pkg and closest_ray_segment_hit.
`timescale 1ns / 1ps

module crsh_checker import crsh_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_op,
  input logic               out_valid,
  input logic [2:0]         out_status,
  input logic [7:0]         out_seg_index,
  input logic signed [15:0] out_hit_x,
  input logic signed [15:0] out_hit_y,
  input logic [16:0]        out_hit_distance,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // A load request answers in the next cycle with a load status.
  a_load_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == OP_LOAD) |=>
      out_valid && ((out_status == ST_LOADED) || (out_status == ST_FULL)))
    else $error("load request not answered with a load status");

  // A cast request holds busy in the following cycle.
  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op != OP_LOAD) && (in_op != OP_CLEAR) |=> busy)
    else $error("cast request did not raise busy");

  // Results other than a hit carry zero payload.
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_HIT) |->
      (out_seg_index == 8'd0) && (out_hit_x == 16'sd0) &&
      (out_hit_y == 16'sd0) && (out_hit_distance == 17'd0))
    else $error("non-hit result with nonzero payload");

  // A cast result comes only after a busy period.
  a_cast_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == ST_HIT) || (out_status == ST_NOHIT)) |->
      $past(busy))
    else $error("cast result without a busy period");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind closest_ray_segment_hit crsh_checker u_crsh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_seg_index    (out_seg_index),
  .out_hit_x        (out_hit_x),
  .out_hit_y        (out_hit_y),
  .out_hit_distance (out_hit_distance),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);
